[hw/rtl/egs_pkg.sv]
`default_nettype none

package egs_pkg;

  // Width of the internal byte counter; saturates at its all-ones value.
  localparam int unsigned OffsetWidth = 16;
  localparam int unsigned BoundWidth  = 16;
  localparam int unsigned CodeWidth   = 21;
  localparam int unsigned FifoDepth   = 4;
  localparam int unsigned FifoPtrW    = $clog2(FifoDepth);
  localparam int unsigned FifoCntW    = $clog2(FifoDepth + 1);

  localparam logic [CodeWidth-1:0] CpZwj        = 21'h0200D;
  localparam logic [CodeWidth-1:0] CpKeycap     = 21'h020E3;
  localparam logic [CodeWidth-1:0] CpVs16       = 21'h0FE0F;
  localparam logic [CodeWidth-1:0] CpVs1        = 21'h0FE00;
  localparam logic [CodeWidth-1:0] CpReplace    = 21'h0FFFD;
  localparam logic [CodeWidth-1:0] CpRiFirst    = 21'h1F1E6;
  localparam logic [CodeWidth-1:0] CpRiLast     = 21'h1F1FF;
  localparam logic [CodeWidth-1:0] CpSkinFirst  = 21'h1F3FB;
  localparam logic [CodeWidth-1:0] CpSkinLast   = 21'h1F3FF;
  localparam logic [CodeWidth-1:0] CpTagFirst   = 21'hE0020;
  localparam logic [CodeWidth-1:0] CpTagLast    = 21'hE007F;
  localparam logic [CodeWidth-1:0] CpPictFirst  = 21'h1F000;
  localparam logic [CodeWidth-1:0] CpPictLast   = 21'h1FAFF;

  // Kind of the grapheme held back while the next code point is awaited.
  typedef enum logic [3:0] {
    KIND_NONE   = 4'b0001,
    KIND_PLAIN  = 4'b0010,
    KIND_KEYCAP = 4'b0100,
    KIND_EMOJI  = 4'b1000
  } kind_e;

  typedef struct packed {
    logic [BoundWidth-1:0] offset;
    logic                  emoji;
    logic                  last;
  } result_t;

  function automatic logic in_range(logic [CodeWidth-1:0] c,
                                    logic [CodeWidth-1:0] lo,
                                    logic [CodeWidth-1:0] hi);
    return (c >= lo) && (c <= hi);
  endfunction

  function automatic logic is_regional(logic [CodeWidth-1:0] c);
    return in_range(c, CpRiFirst, CpRiLast);
  endfunction

  function automatic logic is_extender(logic [CodeWidth-1:0] c);
    return (c == CpZwj) || in_range(c, CpVs1, CpVs16) ||
           in_range(c, CpSkinFirst, CpSkinLast) || (c == CpKeycap) ||
           in_range(c, CpTagFirst, CpTagLast);
  endfunction

  function automatic logic is_emoji_start(logic [CodeWidth-1:0] c);
    return in_range(c, CpPictFirst, CpPictLast) ||
           in_range(c, 21'h02600, 21'h027BF) ||
           in_range(c, 21'h02B00, 21'h02BFF) ||
           in_range(c, 21'h02300, 21'h023FF) ||
           (c == 21'h0203C) || (c == 21'h02049) ||
           in_range(c, 21'h02194, 21'h02199) ||
           (c == 21'h021A9) || (c == 21'h021AA) ||
           (c == 21'h02122) || (c == 21'h02139) ||
           in_range(c, 21'h025AA, 21'h025FF) ||
           (c == 21'h02934) || (c == 21'h02935) ||
           (c == 21'h03030) || (c == 21'h0303D) ||
           (c == 21'h03297) || (c == 21'h03299) ||
           is_regional(c);
  endfunction

  // '#', '*' and the ASCII digits
  function automatic logic is_keycap_base(logic [CodeWidth-1:0] c);
    return (c == 21'h00023) || (c == 21'h0002A) || in_range(c, 21'h00030, 21'h00039);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/emoji_grapheme_segmenter_unit.sv]
`default_nettype none

// Emoji grapheme segmenter. Takes a UTF-8 string one byte per input beat,
// end_of_string_i marking its last byte, and returns one beat per grapheme:
// the byte offset just past the grapheme (counted from 1, low 16 bits of a
// saturating counter), whether it is an emoji cluster, and a last flag on the
// grapheme flushed at the end of the string. Decoding is lenient: a stray
// continuation byte reads as U+FFFD, bytes inside a sequence are taken as
// continuations unchecked, and a sequence cut short by the end of the string
// keeps the bits received so far. A grapheme is reported once the following
// code point shows that it has ended, so results trail the input by one code
// point; the last byte of a string can give two beats. Throughput is one byte
// per cycle: decoding, classification and the grapheme state update are one
// combinational step from the state registers into a four-entry result queue.
// The input stalls only while that queue holds more than two beats, i.e. when
// the output side is itself stalling. After the last byte the decoder and
// grapheme state reset, so the next byte starts a new string at offset zero.
module emoji_grapheme_segmenter_unit
  import egs_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [7:0]            byte_value_i,
  input  wire logic                  end_of_string_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [BoundWidth-1:0]      boundary_offset_o,
  output logic                       is_emoji_cluster_o,
  output logic                       last_boundary_o
);

  localparam logic [OffsetWidth-1:0] PosMax = '1;

  // decoder and grapheme state
  logic [CodeWidth-1:0]   acc_q, acc_d;
  logic [1:0]             rem_q, rem_d;
  logic [OffsetWidth-1:0] pos_q, pos_d;
  kind_e                  kind_q, kind_d;
  logic [OffsetWidth-1:0] pend_q, pend_d;
  logic                   ri_start_q, ri_start_d;
  logic                   single_q, single_d;
  logic                   zwj_q, zwj_d;

  // result queue
  result_t               fifo_q [FifoDepth];
  logic [FifoPtrW-1:0]   wp_q, rp_q;
  logic [FifoCntW-1:0]   cnt_q;

  logic                  in_acc, out_acc;
  logic                  have;
  logic [CodeWidth-1:0]  cp;
  logic                  emit0, emit1;
  result_t               res0, res1;
  logic [1:0]            n_push;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // room for two beats is needed before a byte is taken
  assign in_stall_o  = cnt_q > FifoCntW'(FifoDepth - 2);
  assign out_valid_o = cnt_q != '0;

  always_comb begin
    logic [OffsetWidth-1:0] pos_n;
    logic                   absorb;
    logic                   start_new;
    logic [31:0]            pend_wide;

    acc_d      = acc_q;
    rem_d      = rem_q;
    pos_d      = pos_q;
    kind_d     = kind_q;
    pend_d     = pend_q;
    ri_start_d = ri_start_q;
    single_d   = single_q;
    zwj_d      = zwj_q;
    have       = 1'b0;
    cp         = '0;
    emit0      = 1'b0;
    emit1      = 1'b0;
    res0       = '0;
    res1       = '0;
    absorb     = 1'b0;
    start_new  = 1'b0;
    pend_wide  = 32'(pend_q);

    pos_n = (pos_q != PosMax) ? pos_q + 1'b1 : PosMax;

    if (in_acc) begin
      pos_d = pos_n;

      // UTF-8 decode
      if (rem_q == 2'd0) begin
        if (!byte_value_i[7]) begin
          cp   = CodeWidth'(byte_value_i);
          have = 1'b1;
        end else if (!byte_value_i[6]) begin
          cp   = CpReplace;
          have = 1'b1;
        end else if (!byte_value_i[5]) begin
          acc_d = CodeWidth'(byte_value_i[4:0]);
          rem_d = 2'd1;
        end else if (!byte_value_i[4]) begin
          acc_d = CodeWidth'(byte_value_i[3:0]);
          rem_d = 2'd2;
        end else begin
          acc_d = CodeWidth'(byte_value_i[2:0]);
          rem_d = 2'd3;
        end
      end else begin
        acc_d = {acc_q[CodeWidth-7:0], byte_value_i[5:0]};
        rem_d = rem_q - 2'd1;
        if (rem_d == 2'd0) begin
          cp   = acc_d;
          have = 1'b1;
        end
      end
      // truncated sequence at the end: take what has arrived
      if (end_of_string_i && !have) begin
        cp   = acc_d;
        have = 1'b1;
      end

      // grapheme grouping
      if (have) begin
        case (kind_q)
          KIND_EMOJI: begin
            if (is_extender(cp) ||
                (zwj_q && (is_emoji_start(cp) || is_keycap_base(cp))) ||
                (ri_start_q && single_q && is_regional(cp))) begin
              absorb   = 1'b1;
              pend_d   = pos_n;
              single_d = 1'b0;
              zwj_d    = cp == CpZwj;
            end else begin
              emit0 = 1'b1;
              res0  = '{offset: pend_wide[BoundWidth-1:0], emoji: 1'b1, last: 1'b0};
            end
          end
          KIND_KEYCAP: begin
            if ((cp == CpVs16) || (cp == CpKeycap)) begin
              absorb     = 1'b1;
              kind_d     = KIND_EMOJI;
              pend_d     = pos_n;
              ri_start_d = 1'b0;
              single_d   = 1'b0;
              zwj_d      = 1'b0;
            end else begin
              emit0 = 1'b1;
              res0  = '{offset: pend_wide[BoundWidth-1:0], emoji: 1'b0, last: 1'b0};
            end
          end
          KIND_PLAIN: begin
            emit0 = 1'b1;
            res0  = '{offset: pend_wide[BoundWidth-1:0], emoji: 1'b0, last: 1'b0};
          end
          default: begin
          end
        endcase
        start_new = !absorb;
      end

      if (start_new) begin
        pend_d     = pos_n;
        ri_start_d = 1'b0;
        single_d   = 1'b0;
        zwj_d      = 1'b0;
        if (is_emoji_start(cp)) begin
          kind_d     = KIND_EMOJI;
          ri_start_d = is_regional(cp);
          single_d   = 1'b1;
        end else if (is_keycap_base(cp)) begin
          kind_d = KIND_KEYCAP;
        end else begin
          kind_d = KIND_PLAIN;
        end
      end

      // flush the held grapheme and start afresh
      if (end_of_string_i) begin
        pend_wide = 32'(pend_d);
        if (kind_d != KIND_NONE) begin
          emit1 = 1'b1;
          res1  = '{offset: pend_wide[BoundWidth-1:0], emoji: kind_d == KIND_EMOJI,
                    last: 1'b1};
        end
        acc_d      = '0;
        rem_d      = '0;
        pos_d      = '0;
        kind_d     = KIND_NONE;
        pend_d     = '0;
        ri_start_d = 1'b0;
        single_d   = 1'b0;
        zwj_d      = 1'b0;
      end
    end
  end

  assign n_push = {1'b0, emit0} + {1'b0, emit1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      rem_q      <= '0;
      pos_q      <= '0;
      kind_q     <= KIND_NONE;
      pend_q     <= '0;
      ri_start_q <= 1'b0;
      single_q   <= 1'b0;
      zwj_q      <= 1'b0;
      wp_q       <= '0;
      rp_q       <= '0;
      cnt_q      <= '0;
    end else begin
      acc_q      <= acc_d;
      rem_q      <= rem_d;
      pos_q      <= pos_d;
      kind_q     <= kind_d;
      pend_q     <= pend_d;
      ri_start_q <= ri_start_d;
      single_q   <= single_d;
      zwj_q      <= zwj_d;
      wp_q       <= wp_q + FifoPtrW'(n_push);
      if (out_acc) begin
        rp_q <= rp_q + 1'b1;
      end
      cnt_q <= cnt_q + FifoCntW'(n_push) - FifoCntW'(out_acc);
    end
  end

  // queue payload; the flush beat goes behind the ordinary one when both occur
  always_ff @(posedge clk_i) begin
    if (emit0) begin
      fifo_q[wp_q] <= res0;
    end
    if (emit1) begin
      fifo_q[wp_q + FifoPtrW'(emit0)] <= res1;
    end
  end

  assign boundary_offset_o  = fifo_q[rp_q].offset;
  assign is_emoji_cluster_o = fifo_q[rp_q].emoji;
  assign last_boundary_o    = fifo_q[rp_q].last;

`ifndef SYNTH
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FifoCntW'(FifoDepth))
    else $error("result queue count out of range");

  a_two_only_at_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit0 && emit1) |-> (in_acc && end_of_string_i))
    else $error("two beats from a byte that is not the last");

  a_reset_after_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && end_of_string_i) |=> (pos_q == '0 && kind_q == KIND_NONE && rem_q == 2'd0))
    else $error("state not cleared after end of string");

  a_queue_track : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wp_q == rp_q))
    else $error("empty queue with pointers apart");
`endif

endmodule

`default_nettype wire
